[sv/binary_to_decimal_ascii_defines.svh]
// Assertion macros used by the checker of the binary to decimal ASCII block.
// No dependencies; included by the checker file.
`ifndef BINARY_TO_DECIMAL_ASCII_DEFINES_SVH
`define BINARY_TO_DECIMAL_ASCII_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B2DA_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B2DA_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/b2da_pkg.sv]
// Package of the binary to decimal ASCII block: widths, constants and types.
// No dependencies; used by the design modules of the block.
`default_nettype none

package b2da_pkg;

  localparam int VALUE_BITS = 32;
  localparam int NUM_DIGITS = 10;
  localparam int DIGIT_W    = 4;
  localparam int POS_W      = 4;
  localparam int CHAR_W     = 6;
  localparam int BIT_CNT_W  = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  typedef logic [DIGIT_W-1:0] digit_t;

  typedef struct packed {
    logic clear;
    logic shift;
  } cell_ctl_t;

endpackage

`default_nettype wire

[sv/b2da_cell.sv]
// One BCD digit cell of the double dabble shift chain.
// Depends on b2da_pkg for the digit type and the control struct.
`default_nettype none

module b2da_cell (
  input  wire logic               clk,
  input  wire b2da_pkg::cell_ctl_t ctl,
  input  wire logic               bit_in,
  output logic                    bit_out,
  output b2da_pkg::digit_t        digit
);

  b2da_pkg::digit_t digit_r;
  b2da_pkg::digit_t adj_w;

  always_comb begin
    if (digit_r >= b2da_pkg::DIGIT_W'(5)) begin
      adj_w = digit_r + b2da_pkg::DIGIT_W'(3);
    end else begin
      adj_w = digit_r;
    end
  end

  assign bit_out = adj_w[b2da_pkg::DIGIT_W-1];
  assign digit   = digit_r;

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit_r <= '0;
    end else if (ctl.shift) begin
      digit_r <= {adj_w[b2da_pkg::DIGIT_W-2:0], bit_in};
    end
  end

endmodule

`default_nettype wire

[sv/binary_to_decimal_ascii.sv]
// Top level of the binary to decimal ASCII converter: sequencer, input shift
// register, chain of b2da_cell digit cells and output register. Uses b2da_pkg.
//
//   Channel | Direction | Transaction carries
//   in_     | slave     | one unsigned value to convert
//   out_    | master    | one ASCII digit, its position, digit count, tlast on final digit
//
// An item passes through an accept step, a conversion phase in which the
// chain of ten digit cells takes one input bit per cycle, and an emission
// phase that sends its digits one at a time.
// A new value is accepted while the final digit still waits in the output register.
// Output stalls hold the current digit and pause the emission.
// Reset is synchronous and active low; it clears the sequencer and output valid.
`default_nettype none

module binary_to_decimal_ascii (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [5:0] digit_char, [9:6] digit_position,
                                       // [13:10] digit_count, [15:14] zero
  output logic             out_tlast
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [b2da_pkg::BIT_CNT_W-1:0] bit_cnt_r, bit_cnt_nxt;
  logic [b2da_pkg::VALUE_BITS-1:0] sh_r, sh_nxt;
  logic [b2da_pkg::POS_W-1:0] pos_r, pos_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [b2da_pkg::CHAR_W-1:0] out_char_r, out_char_nxt;
  logic [b2da_pkg::POS_W-1:0] out_pos_r, out_pos_nxt;
  logic [b2da_pkg::POS_W-1:0] out_cnt_r, out_cnt_nxt;
  logic out_last_r, out_last_nxt;

  logic in_fire_w;
  logic out_free_w;
  b2da_pkg::cell_ctl_t ctl_w;
  b2da_pkg::digit_t digit_w [b2da_pkg::NUM_DIGITS];
  logic [b2da_pkg::NUM_DIGITS-1:0] chain_in_w;
  logic [b2da_pkg::POS_W-1:0] digit_cnt_w;
  logic [b2da_pkg::POS_W-1:0] rd_idx_w;
  b2da_pkg::digit_t sel_digit_w;
  logic is_last_w;

  assign in_tready  = (state_r == ST_IDLE);
  assign in_fire_w  = in_tvalid & in_tready;
  assign out_free_w = ~out_valid_r | out_tready;

  assign ctl_w.clear = in_fire_w;
  assign ctl_w.shift = (state_r == ST_CONV);

  assign chain_in_w[0] = sh_r[b2da_pkg::VALUE_BITS-1];

  for (genvar i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin : g_cell
    if (i < b2da_pkg::NUM_DIGITS - 1) begin : g_mid
      b2da_cell u_cell (
        .clk     (clk),
        .ctl     (ctl_w),
        .bit_in  (chain_in_w[i]),
        .bit_out (chain_in_w[i+1]),
        .digit   (digit_w[i])
      );
    end else begin : g_top
      b2da_cell u_cell (
        .clk     (clk),
        .ctl     (ctl_w),
        .bit_in  (chain_in_w[i]),
        .bit_out (),
        .digit   (digit_w[i])
      );
    end
  end

  always_comb begin
    digit_cnt_w = b2da_pkg::POS_W'(1);
    for (int i = 1; i < b2da_pkg::NUM_DIGITS; i++) begin
      if (digit_w[i] != '0) begin
        digit_cnt_w = b2da_pkg::POS_W'(i + 1);
      end
    end
  end

  assign rd_idx_w    = digit_cnt_w - pos_r - b2da_pkg::POS_W'(1);
  assign sel_digit_w = digit_w[rd_idx_w];
  assign is_last_w   = ((pos_r + b2da_pkg::POS_W'(1)) == digit_cnt_w);

  always_comb begin
    state_nxt     = state_r;
    bit_cnt_nxt   = bit_cnt_r;
    sh_nxt        = sh_r;
    pos_nxt       = pos_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_char_nxt  = out_char_r;
    out_pos_nxt   = out_pos_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire_w) begin
          sh_nxt      = in_tdata[b2da_pkg::VALUE_BITS-1:0];
          bit_cnt_nxt = '0;
          pos_nxt     = '0;
          state_nxt   = ST_CONV;
        end
      end
      ST_CONV: begin
        sh_nxt      = sh_r << 1;
        bit_cnt_nxt = bit_cnt_r + b2da_pkg::BIT_CNT_W'(1);
        if (bit_cnt_r == b2da_pkg::BIT_CNT_W'(b2da_pkg::VALUE_BITS - 1)) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free_w) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = b2da_pkg::ASCII_ZERO
                        + {{(b2da_pkg::CHAR_W - b2da_pkg::DIGIT_W){1'b0}}, sel_digit_w};
          out_pos_nxt   = pos_r;
          out_cnt_nxt   = digit_cnt_w;
          out_last_nxt  = is_last_w;
          pos_nxt       = pos_r + b2da_pkg::POS_W'(1);
          if (is_last_w) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bit_cnt_r  <= bit_cnt_nxt;
    sh_r       <= sh_nxt;
    pos_r      <= pos_nxt;
    out_char_r <= out_char_nxt;
    out_pos_r  <= out_pos_nxt;
    out_cnt_r  <= out_cnt_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_cnt_r, out_pos_r, out_char_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[sv/b2da_checker.sv]
// Port-level checker of the binary to decimal ASCII converter, bound to the top level.
// Depends on binary_to_decimal_ascii_defines.svh for the assertion macros.
`default_nettype none

`include "binary_to_decimal_ascii_defines.svh"

module b2da_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic [31:0] in_tdata,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tlast
);

  logic out_fire_w;
  logic in_seen_w;

  assign out_fire_w = out_tvalid & out_tready;
  assign in_seen_w  = in_tvalid & in_tready & (in_tdata == in_tdata);

  `B2DA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "Stalled result changed.")
  `B2DA_ASSERT_SAME(a_char_range, clk, rst_n, out_tvalid, out_tdata[5:0] >= 6'd48 && out_tdata[5:0] <= 6'd57, "Digit character out of range.")
  `B2DA_ASSERT_SAME(a_count_range, clk, rst_n, out_tvalid, out_tdata[13:10] >= 4'd1 && out_tdata[13:10] <= 4'd10 && out_tdata[9:6] < out_tdata[13:10], "Digit count or position out of range.")
  `B2DA_ASSERT_SAME(a_last_pos, clk, rst_n, out_tvalid, out_tlast == ((out_tdata[9:6] + 4'd1) == out_tdata[13:10]), "tlast does not match the final position.")
  `B2DA_ASSERT_NEXT(a_pos_step, clk, rst_n, out_fire_w && !out_tlast && !in_seen_w, !out_tvalid || (out_tdata[9:6] == $past(out_tdata[9:6]) + 4'd1 && out_tdata[13:10] == $past(out_tdata[13:10])), "Digit positions are not consecutive.")

endmodule

bind binary_to_decimal_ascii b2da_checker u_b2da_checker (.*);

`default_nettype wire
